[rtl/lfid_pkg.sv]
// Shared types and constants for the lowest-free id allocator.
// Used by lfid_heap_mem and lowest_free_id_allocator_top; no dependencies.
package lfid_pkg;

    localparam int ID_W = 8;
    localparam int ST_W = 2;

    localparam int DEF_ID_COUNT   = 256;
    localparam int DEF_HEAP_DEPTH = 256;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] free_id;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0] given_id;
        logic [ST_W-1:0] status;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_ISSUE,
        S_DN_L,
        S_DN_R,
        S_UP_WAIT,
        S_UP_FIN
    } t_state;

endpackage

[rtl/lfid_heap_mem.sv]
// Heap storage: one write port, one read port, registered read data.
// Depends on lfid_pkg for the entry width.
module lfid_heap_mem #(
    parameter int DEPTH = lfid_pkg::DEF_HEAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [lfid_pkg::ID_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [lfid_pkg::ID_W-1:0] o_rdata
);
    import lfid_pkg::*;

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lowest_free_id_allocator_top.sv]
// Lowest-free id allocator: min-heap of freed ids in one RAM plus a high-water counter.
// Depends on lfid_pkg and lfid_heap_mem.
// Counter allocate, rejected free, counter step-down, push to an empty heap: result in
// the cycle after the accept. Pop reads the root and, unless that empties the heap, the
// last entry, then two children per level; push reads one parent per level climbed.
// Synchronous reset empties the heap and clears the counter; the receiver cannot stall.
module lowest_free_id_allocator_top #(
    parameter int ID_COUNT   = lfid_pkg::DEF_ID_COUNT,
    parameter int HEAP_DEPTH = lfid_pkg::DEF_HEAP_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lfid_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output lfid_pkg::t_res o_result
);
    import lfid_pkg::*;

    localparam int HW_W  = $clog2(ID_COUNT + 1);
    localparam int CMP_W = (HW_W > ID_W) ? HW_W : ID_W;
    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int NW    = $clog2(HEAP_DEPTH + 1);
    localparam int CW    = AW + 2;

    t_state          r_state, n_state;
    logic [HW_W-1:0] r_hw, n_hw;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_hole, n_hole;
    logic [AW-1:0]   r_par, n_par;
    logic [ID_W-1:0] r_val, n_val;
    logic [ID_W-1:0] r_child, n_child;
    logic [ID_W-1:0] r_given, n_given;
    logic            r_vld, n_vld;
    t_res            r_res, n_res;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [ID_W-1:0] mem_wdata, mem_rdata;

    logic [CMP_W-1:0] id_x, hw_x;
    logic [CW-1:0]    w_left, w_right, cnt_x;
    logic             pick_right;
    logic [ID_W-1:0]  cmin;
    logic [AW-1:0]    cidx;

    lfid_heap_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign id_x    = CMP_W'(i_cmd.free_id);
    assign hw_x    = CMP_W'(r_hw);
    assign w_left  = {1'b0, r_hole, 1'b1};
    assign w_right = w_left + CW'(1);
    assign cnt_x   = CW'(r_cnt);

    // right child wins only when strictly smaller, as the heap order requires
    assign pick_right = mem_rdata < r_child;
    assign cmin       = pick_right ? mem_rdata : r_child;
    assign cidx       = pick_right ? w_right[AW-1:0] : w_left[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= '0;
            r_cnt   <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_cnt   <= n_cnt;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole  <= n_hole;
        r_par   <= n_par;
        r_val   <= n_val;
        r_child <= n_child;
        r_given <= n_given;
        r_res   <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_hw      = r_hw;
        n_cnt     = r_cnt;
        n_hole    = r_hole;
        n_par     = r_par;
        n_val     = r_val;
        n_child   = r_child;
        n_given   = r_given;
        n_vld     = 1'b0;
        n_res     = '{given_id: '0, status: ST_OK};
        mem_we    = 1'b0;
        mem_waddr = r_hole;
        mem_wdata = r_val;
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd.command == CMD_ALLOC) begin
                        if (r_cnt != '0) begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_cnt     = r_cnt - NW'(1);
                            n_state   = S_POP_ROOT;
                        end else if (r_hw < HW_W'(ID_COUNT)) begin
                            n_vld          = 1'b1;
                            n_res.given_id = hw_x[ID_W-1:0];
                            n_hw           = r_hw + HW_W'(1);
                        end else begin
                            n_vld        = 1'b1;
                            n_res.status = ST_EXHAUSTED;
                        end
                    end else begin
                        if (id_x >= hw_x) begin
                            n_vld        = 1'b1;
                            n_res.status = ST_RANGE;
                        end else if (id_x == hw_x - CMP_W'(1)) begin
                            n_vld = 1'b1;
                            n_hw  = r_hw - HW_W'(1);
                        end else if (r_cnt >= NW'(HEAP_DEPTH)) begin
                            n_vld        = 1'b1;
                            n_res.status = ST_FULL;
                        end else begin
                            n_cnt  = r_cnt + NW'(1);
                            n_val  = i_cmd.free_id;
                            n_hole = r_cnt[AW-1:0];
                            if (r_cnt == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_cmd.free_id;
                                n_vld     = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = (r_cnt[AW-1:0] - AW'(1)) >> 1;
                                n_par     = (r_cnt[AW-1:0] - AW'(1)) >> 1;
                                n_state   = S_UP_WAIT;
                            end
                        end
                    end
                end
            end

            S_POP_ROOT: begin
                n_given = mem_rdata;
                if (r_cnt == '0) begin
                    n_vld          = 1'b1;
                    n_res.given_id = mem_rdata;
                    n_state        = S_IDLE;
                end else begin
                    // fetch the last entry, it refills the root
                    mem_re    = 1'b1;
                    mem_raddr = r_cnt[AW-1:0];
                    n_state   = S_POP_LAST;
                end
            end

            S_POP_LAST: begin
                n_val   = mem_rdata;
                n_hole  = '0;
                n_state = S_DN_ISSUE;
            end

            S_DN_ISSUE: begin
                if (w_left < cnt_x) begin
                    mem_re    = 1'b1;
                    mem_raddr = w_left[AW-1:0];
                    n_state   = S_DN_L;
                end else begin
                    mem_we         = 1'b1;
                    n_vld          = 1'b1;
                    n_res.given_id = r_given;
                    n_state        = S_IDLE;
                end
            end

            S_DN_L: begin
                n_child = mem_rdata;
                if (w_right < cnt_x) begin
                    mem_re    = 1'b1;
                    mem_raddr = w_right[AW-1:0];
                    n_state   = S_DN_R;
                end else if (mem_rdata < r_val) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_hole    = w_left[AW-1:0];
                    n_state   = S_DN_ISSUE;
                end else begin
                    mem_we         = 1'b1;
                    n_vld          = 1'b1;
                    n_res.given_id = r_given;
                    n_state        = S_IDLE;
                end
            end

            S_DN_R: begin
                if (cmin < r_val) begin
                    // move the smaller child up into the hole
                    mem_we    = 1'b1;
                    mem_wdata = cmin;
                    n_hole    = cidx;
                    n_state   = S_DN_ISSUE;
                end else begin
                    mem_we         = 1'b1;
                    n_vld          = 1'b1;
                    n_res.given_id = r_given;
                    n_state        = S_IDLE;
                end
            end

            S_UP_WAIT: begin
                if (r_val < mem_rdata) begin
                    // drop the parent into the hole, climb one level
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    n_hole    = r_par;
                    if (r_par == '0) begin
                        n_state = S_UP_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = (r_par - AW'(1)) >> 1;
                        n_par     = (r_par - AW'(1)) >> 1;
                    end
                end else begin
                    mem_we  = 1'b1;
                    n_vld   = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_UP_FIN: begin
                mem_we  = 1'b1;
                n_vld   = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_vld;
    assign o_result = r_res;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(HEAP_DEPTH))
        else $error("heap count above depth");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= HW_W'(ID_COUNT))
        else $error("high-water counter above id count");

    a_hole_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_ISSUE) |-> (NW'(r_hole) < r_cnt))
        else $error("sift-down hole outside live heap");

    a_no_word_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_valid)
        else $error("result word strobed as a heap walk begins");

    a_err_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.given_id == '0))
        else $error("nonzero id on a failed command");

endmodule
